// ----- hw/rtl/resp_token_stream_parser_macros.svh -----
// ----------------------------------------------------------------------------
// RESP token stream parser assertion macros
// Shared overlapping-implication and next-cycle property forms.
// ----------------------------------------------------------------------------
`ifndef RESP_TOKEN_STREAM_PARSER_MACROS_SVH
`define RESP_TOKEN_STREAM_PARSER_MACROS_SVH

// check cons in the same cycle as ante
`define RTSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtsp: same-cycle check failed");

// check cons in the cycle after ante
`define RTSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtsp: next-cycle check failed");

`endif

// ----- hw/rtl/rtsp_pkg.sv -----
// ----------------------------------------------------------------------------
// RESP token stream parser package
// Event, error, phase and status codes, character constants and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package rtsp_pkg;

    localparam int DEF_MAX_DEPTH = 16;
    localparam int DEF_LEN_BITS  = 32;
    localparam int NUM_W         = 64;
    localparam int DEPTH_W       = 5;

    typedef enum logic [3:0] {
        EV_SIMPLE_BYTE = 4'd0,
        EV_SIMPLE_END  = 4'd1,
        EV_ERROR_BYTE  = 4'd2,
        EV_ERROR_END   = 4'd3,
        EV_INTEGER     = 4'd4,
        EV_BULK_HDR    = 4'd5,
        EV_BULK_BYTE   = 4'd6,
        EV_BULK_END    = 4'd7,
        EV_NIL_BULK    = 4'd8,
        EV_ARRAY_HDR   = 4'd9,
        EV_NIL_ARRAY   = 4'd10,
        EV_PARSE_ERR   = 4'd11
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_PREFIX    = 3'd1,
        ERR_NO_LF     = 3'd2,
        ERR_BAD_CRLF  = 3'd3,
        ERR_NO_DIGITS = 3'd4,
        ERR_OVERFLOW  = 3'd5,
        ERR_EARLY_END = 3'd6,
        ERR_TOO_DEEP  = 3'd7
    } t_err;

    typedef enum logic [3:0] {
        PH_PREFIX,
        PH_SIMPLE,
        PH_SIMPLE_LF,
        PH_ERRTXT,
        PH_ERRTXT_LF,
        PH_NUM_LEAD,
        PH_NUM_DIGITS,
        PH_NUM_SKIP,
        PH_NUM_LF,
        PH_BULK_DATA,
        PH_BULK_CR,
        PH_BULK_LF
    } t_phase;

    typedef enum logic [1:0] {
        NK_INT,
        NK_BULK,
        NK_ARRAY
    } t_num_kind;

    typedef enum logic [1:0] {
        ST_ACTIVE,
        ST_DONE,
        ST_ERROR
    } t_status;

    typedef struct packed {
        logic push;
        logic complete;
        logic clear;
    } t_stk_cmd;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

`default_nettype wire

// ----- hw/rtl/rtsp_stack.sv -----
// ----------------------------------------------------------------------------
// RESP array nesting stack
// Elements-left counters per open array; push on header, retire on value end.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_stack #(
    parameter int MAX_DEPTH = rtsp_pkg::DEF_MAX_DEPTH,
    parameter int LEN_BITS  = rtsp_pkg::DEF_LEN_BITS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  rtsp_pkg::t_stk_cmd             i_cmd,
    input  wire [LEN_BITS-1:0]             i_push_count,
    output logic [$clog2(MAX_DEPTH+1)-1:0] o_level,
    output logic [$clog2(MAX_DEPTH+1)-1:0] o_level_after,
    output logic                           o_top_done
);
    import rtsp_pkg::*;

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int IW = $clog2(MAX_DEPTH);

    logic [LW-1:0]       r_level;
    logic [LEN_BITS-1:0] r_cnt [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] r_one;

    logic          found;
    logic [IW-1:0] tgt;

    always_comb begin
        found = 1'b0;
        tgt   = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if ((LW'(i) < r_level) && !r_one[i]) begin
                found = 1'b1;
                tgt   = IW'(i);
            end
        end
    end

    assign o_level       = r_level;
    assign o_level_after = found ? (LW'(tgt) + LW'(1)) : '0;
    assign o_top_done    = !found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.clear) begin
            r_level <= '0;
        end else if (i_cmd.push) begin
            r_level <= r_level + LW'(1);
        end else if (i_cmd.complete) begin
            r_level <= o_level_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            r_cnt[r_level[IW-1:0]] <= i_push_count;
            r_one[r_level[IW-1:0]] <= (i_push_count == LEN_BITS'(1));
        end else if (i_cmd.complete && !i_cmd.clear && found) begin
            r_cnt[tgt] <= r_cnt[tgt] - LEN_BITS'(1);
            r_one[tgt] <= (r_cnt[tgt] == LEN_BITS'(2));
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/resp_token_stream_parser.sv -----
// Structure: a request is registered in the input register on acceptance, and
// its event is then registered in the output register once that is free.
// Throughput: one byte per cycle while the output is not stalled.
// Output stalls hold the event; a new byte is still taken if the stage drains.
// Reset (synchronous, active low) clears phase, status, stack level, valids.
// ----------------------------------------------------------------------------
// RESP token stream parser
// Byte-serial RESP2 parser emitting one token event per byte at most.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_token_stream_parser #(
    parameter int MAX_DEPTH = rtsp_pkg::DEF_MAX_DEPTH,
    parameter int LEN_BITS  = rtsp_pkg::DEF_LEN_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire                                i_kind,
    input  wire [7:0]                          i_data_byte,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [3:0]                         o_event_res,
    output logic signed [rtsp_pkg::NUM_W-1:0]  o_number_value,
    output logic [7:0]                         o_text_byte,
    output logic [rtsp_pkg::DEPTH_W-1:0]       o_nesting_depth,
    output logic [2:0]                         o_error_code,
    output logic                               o_message_done
);
    import rtsp_pkg::*;

    localparam int LW = $clog2(MAX_DEPTH + 1);

    logic        r_in_valid;
    logic        r_in_kind;
    logic [7:0]  r_in_byte;

    t_phase              r_phase, n_phase;
    t_num_kind           r_nkind, n_nkind;
    t_status             r_status, n_status;
    logic [NUM_W-1:0]    r_acc, n_acc;
    logic                r_neg, n_neg;
    logic                r_seen, n_seen;
    logic                r_ovf, n_ovf;
    logic [LEN_BITS-1:0] r_bulk_left, n_bulk_left;

    logic                r_out_valid;
    t_event              r_out_ev;
    logic [NUM_W-1:0]    r_out_val;
    logic [7:0]          r_out_byte;
    logic [DEPTH_W-1:0]  r_out_dep;
    t_err                r_out_err;
    logic                r_out_done;

    logic               fire;
    logic               emit;
    t_event             ev;
    logic [NUM_W-1:0]   val;
    logic [7:0]         tb;
    logic [DEPTH_W-1:0] dep;
    t_err               ec;
    logic               dn;
    t_stk_cmd           cmd;

    logic [LW-1:0]      level, level_after;
    logic               top_done;
    logic [DEPTH_W-1:0] dep_now, dep_after;

    logic               is_dig, is_blank;
    logic [NUM_W+3:0]   acc10, limit;
    logic               ovf_now;
    logic [NUM_W-1:0]   v;
    logic               len_wide;

    rtsp_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .LEN_BITS  (LEN_BITS)
    ) u_stack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_push_count  (r_acc[LEN_BITS-1:0]),
        .o_level       (level),
        .o_level_after (level_after),
        .o_top_done    (top_done)
    );

    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    assign dep_now   = DEPTH_W'(level);
    assign dep_after = DEPTH_W'(level_after);

    assign is_dig   = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign is_blank = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB) ||
                      (r_in_byte == CH_LF) || (r_in_byte == CH_VT) ||
                      (r_in_byte == CH_FF);
    assign acc10    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + {{NUM_W{1'b0}}, 4'(r_in_byte - CH_ZERO)};
    assign limit    = {4'b0, r_neg, {(NUM_W-1){!r_neg}}};
    assign ovf_now  = acc10 > limit;
    assign v        = r_neg ? (~r_acc + NUM_W'(1)) : r_acc;
    assign len_wide = |(r_acc >> LEN_BITS);

    always_comb begin
        n_phase     = r_phase;
        n_nkind     = r_nkind;
        n_status    = r_status;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_ovf       = r_ovf;
        n_bulk_left = r_bulk_left;
        emit        = 1'b0;
        ev          = EV_SIMPLE_BYTE;
        val         = '0;
        tb          = '0;
        dep         = dep_now;
        ec          = ERR_NONE;
        dn          = 1'b0;
        cmd         = '0;
        if (fire) begin
            if (r_in_kind) begin
                if (r_status == ST_ACTIVE) begin
                    emit = 1'b1;
                    ev   = EV_PARSE_ERR;
                    if (r_phase == PH_SIMPLE_LF || r_phase == PH_ERRTXT_LF ||
                        r_phase == PH_NUM_LF) begin
                        ec = ERR_NO_LF;
                    end else if (r_phase == PH_BULK_CR || r_phase == PH_BULK_LF) begin
                        ec = ERR_BAD_CRLF;
                    end else begin
                        ec = ERR_EARLY_END;
                    end
                end
                n_phase     = PH_PREFIX;
                n_status    = ST_ACTIVE;
                n_acc       = '0;
                n_neg       = 1'b0;
                n_seen      = 1'b0;
                n_ovf       = 1'b0;
                n_bulk_left = '0;
                cmd.clear   = 1'b1;
            end else if (r_status == ST_ACTIVE) begin
                unique case (r_phase)
                    PH_PREFIX: begin
                        n_acc  = '0;
                        n_neg  = 1'b0;
                        n_seen = 1'b0;
                        n_ovf  = 1'b0;
                        priority if (r_in_byte == CH_PLUS) begin
                            n_phase = PH_SIMPLE;
                        end else if (r_in_byte == CH_MINUS) begin
                            n_phase = PH_ERRTXT;
                        end else if (r_in_byte == CH_COLON) begin
                            n_phase = PH_NUM_LEAD;
                            n_nkind = NK_INT;
                        end else if (r_in_byte == CH_DOLLAR) begin
                            n_phase = PH_NUM_LEAD;
                            n_nkind = NK_BULK;
                        end else if (r_in_byte == CH_STAR) begin
                            n_phase = PH_NUM_LEAD;
                            n_nkind = NK_ARRAY;
                        end else begin
                            emit     = 1'b1;
                            ev       = EV_PARSE_ERR;
                            ec       = ERR_PREFIX;
                            n_status = ST_ERROR;
                        end
                    end
                    PH_SIMPLE, PH_ERRTXT: begin
                        if (r_in_byte == CH_CR) begin
                            n_phase = (r_phase == PH_SIMPLE) ? PH_SIMPLE_LF : PH_ERRTXT_LF;
                        end else begin
                            emit = 1'b1;
                            ev   = (r_phase == PH_SIMPLE) ? EV_SIMPLE_BYTE : EV_ERROR_BYTE;
                            tb   = r_in_byte;
                        end
                    end
                    PH_SIMPLE_LF, PH_ERRTXT_LF: begin
                        emit = 1'b1;
                        if (r_in_byte != CH_LF) begin
                            ev       = EV_PARSE_ERR;
                            ec       = ERR_NO_LF;
                            n_status = ST_ERROR;
                        end else begin
                            ev           = (r_phase == PH_SIMPLE_LF) ? EV_SIMPLE_END
                                                                     : EV_ERROR_END;
                            cmd.complete = 1'b1;
                            dn           = top_done;
                            n_phase      = PH_PREFIX;
                            if (top_done) n_status = ST_DONE;
                        end
                    end
                    PH_BULK_DATA: begin
                        emit        = 1'b1;
                        ev          = EV_BULK_BYTE;
                        tb          = r_in_byte;
                        n_bulk_left = r_bulk_left - LEN_BITS'(1);
                        if (r_bulk_left == LEN_BITS'(1)) n_phase = PH_BULK_CR;
                    end
                    PH_BULK_CR: begin
                        if (r_in_byte != CH_CR) begin
                            emit     = 1'b1;
                            ev       = EV_PARSE_ERR;
                            ec       = ERR_BAD_CRLF;
                            n_status = ST_ERROR;
                        end else begin
                            n_phase = PH_BULK_LF;
                        end
                    end
                    PH_BULK_LF: begin
                        emit = 1'b1;
                        if (r_in_byte != CH_LF) begin
                            ev       = EV_PARSE_ERR;
                            ec       = ERR_BAD_CRLF;
                            n_status = ST_ERROR;
                        end else begin
                            ev           = EV_BULK_END;
                            cmd.complete = 1'b1;
                            dn           = top_done;
                            n_phase      = PH_PREFIX;
                            if (top_done) n_status = ST_DONE;
                        end
                    end
                    PH_NUM_LEAD, PH_NUM_DIGITS, PH_NUM_SKIP: begin
                        if (r_in_byte == CH_CR) begin
                            n_phase = PH_NUM_LF;
                        end else if (r_phase == PH_NUM_SKIP) begin
                            n_phase = PH_NUM_SKIP;
                        end else if (is_dig) begin
                            n_seen  = 1'b1;
                            n_phase = PH_NUM_DIGITS;
                            if (!r_ovf) begin
                                if (ovf_now) n_ovf = 1'b1;
                                else         n_acc = acc10[NUM_W-1:0];
                            end
                        end else if (r_phase == PH_NUM_DIGITS) begin
                            n_phase = PH_NUM_SKIP;
                        end else if (is_blank) begin
                            n_phase = PH_NUM_LEAD;
                        end else if (r_in_byte == CH_PLUS || r_in_byte == CH_MINUS) begin
                            n_neg   = (r_in_byte == CH_MINUS);
                            n_phase = PH_NUM_DIGITS;
                        end else begin
                            n_phase = PH_NUM_SKIP;
                        end
                    end
                    PH_NUM_LF: begin
                        emit = 1'b1;
                        val  = v;
                        priority if (r_in_byte != CH_LF) begin
                            ev = EV_PARSE_ERR; ec = ERR_NO_LF; val = '0;
                            n_status = ST_ERROR;
                        end else if (!r_seen) begin
                            ev = EV_PARSE_ERR; ec = ERR_NO_DIGITS; val = '0;
                            n_status = ST_ERROR;
                        end else if (r_ovf) begin
                            ev = EV_PARSE_ERR; ec = ERR_OVERFLOW; val = '0;
                            n_status = ST_ERROR;
                        end else if (r_nkind == NK_INT) begin
                            ev = EV_INTEGER;
                            cmd.complete = 1'b1;
                            dep = dep_after; dn = top_done;
                            n_phase = PH_PREFIX;
                            if (top_done) n_status = ST_DONE;
                        end else if (&v) begin
                            ev = (r_nkind == NK_BULK) ? EV_NIL_BULK : EV_NIL_ARRAY;
                            cmd.complete = 1'b1;
                            dep = dep_after; dn = top_done;
                            n_phase = PH_PREFIX;
                            if (top_done) n_status = ST_DONE;
                        end else if (!r_neg && len_wide) begin
                            ev = EV_PARSE_ERR; ec = ERR_OVERFLOW; val = '0;
                            n_status = ST_ERROR;
                        end else if (r_nkind == NK_BULK) begin
                            ev = EV_BULK_HDR;
                            if (r_neg && (v != '0)) begin
                                cmd.complete = 1'b1;
                                dep = dep_after; dn = top_done;
                                n_phase = PH_PREFIX;
                                if (top_done) n_status = ST_DONE;
                            end else begin
                                n_bulk_left = r_acc[LEN_BITS-1:0];
                                n_phase = (r_neg || r_acc == '0) ? PH_BULK_CR : PH_BULK_DATA;
                            end
                        end else if (r_neg || r_acc == '0) begin
                            ev = EV_ARRAY_HDR;
                            cmd.complete = 1'b1;
                            dep = dep_after; dn = top_done;
                            n_phase = PH_PREFIX;
                            if (top_done) n_status = ST_DONE;
                        end else if (level >= LW'(MAX_DEPTH)) begin
                            ev = EV_PARSE_ERR; ec = ERR_TOO_DEEP; val = '0;
                            n_status = ST_ERROR;
                        end else begin
                            ev = EV_ARRAY_HDR;
                            cmd.push = 1'b1;
                            n_phase = PH_PREFIX;
                        end
                    end
                    default: begin
                        n_phase = PH_PREFIX;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_PREFIX;
            r_nkind     <= NK_INT;
            r_status    <= ST_ACTIVE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_bulk_left <= '0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (fire && emit)  r_out_valid <= 1'b1;
            else if (i_ready)  r_out_valid <= 1'b0;
            r_phase     <= n_phase;
            r_nkind     <= n_nkind;
            r_status    <= n_status;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_seen      <= n_seen;
            r_ovf       <= n_ovf;
            r_bulk_left <= n_bulk_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_data_byte;
        end
        if (fire && emit) begin
            r_out_ev   <= ev;
            r_out_val  <= val;
            r_out_byte <= tb;
            r_out_dep  <= dep;
            r_out_err  <= ec;
            r_out_done <= dn;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_res     = r_out_ev;
    assign o_number_value  = r_out_val;
    assign o_text_byte     = r_out_byte;
    assign o_nesting_depth = r_out_dep;
    assign o_error_code    = r_out_err;
    assign o_message_done  = r_out_done;

endmodule

`default_nettype wire

// ----- hw/rtl/rtsp_checker.sv -----
// ----------------------------------------------------------------------------
// RESP token stream parser port checker
// Port-level checks on output events, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "resp_token_stream_parser_macros.svh"

module rtsp_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           o_valid,
    input wire                           i_ready,
    input wire [3:0]                     o_event_res,
    input wire [2:0]                     o_error_code,
    input wire                           o_message_done,
    input wire [rtsp_pkg::NUM_W-1:0]     o_number_value
);
    import rtsp_pkg::*;

    `RTSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_event_res) && $stable(o_number_value))
    `RTSP_ASSERT_NOW(a_err_code, i_clk, i_rst_n, o_valid,
        (o_event_res == EV_PARSE_ERR) == (o_error_code != ERR_NONE))
    `RTSP_ASSERT_NOW(a_done_event, i_clk, i_rst_n, o_valid && o_message_done,
        o_event_res != EV_SIMPLE_BYTE && o_event_res != EV_ERROR_BYTE &&
        o_event_res != EV_BULK_BYTE && o_event_res != EV_PARSE_ERR)
    `RTSP_ASSERT_NOW(a_nil_value, i_clk, i_rst_n,
        o_valid && (o_event_res == EV_NIL_BULK || o_event_res == EV_NIL_ARRAY),
        &o_number_value)

endmodule

bind resp_token_stream_parser rtsp_checker u_rtsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_event_res    (o_event_res),
    .o_error_code   (o_error_code),
    .o_message_done (o_message_done),
    .o_number_value (o_number_value)
);

`default_nettype wire
